### hw/rtl/tsvr_pkg.sv
// Package for the two-stage volume ramp: field widths, opcodes, reset values
// and the controller state type. No dependencies; used by every RTL file.
`timescale 1ns / 1ps
`default_nettype none

package tsvr_pkg;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int LEVEL_W  = 16;
    localparam int MS_W     = 16;
    localparam int FRAMES_W = 16;
    localparam int RATE_W   = 18;
    localparam int LEFT_W   = 24;
    localparam int GAIN_W   = 17;
    localparam int Q_FRAC   = 15;

    // Serial multiplier: A operand is parallel, B operand is consumed one bit a cycle.
    localparam int MUL_A_W = RATE_W;
    localparam int MUL_B_W = MS_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Serial divider: one quotient bit a cycle.
    localparam int DIV_N_W = PROD_W;
    localparam int DIV_D_W = LEFT_W;

    // Constants.
    localparam logic [LEVEL_W-1:0] UNITY        = LEVEL_W'(32768);
    localparam logic [RATE_W-1:0]  RATE_RESET   = RATE_W'(48000);
    localparam int                 MS_PER_S     = 1000;
    localparam logic [LEFT_W-1:0]  FRAMES_MAX   = {LEFT_W{1'b1}};

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SET_BASE   = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_ADJUST = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE    = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SET_MUL,
        ST_SET_MWAIT,
        ST_SET_DIV,
        ST_SET_DWAIT,
        ST_SET_APPLY,
        ST_STEP_CHECK,
        ST_STEP_MWAIT,
        ST_STEP_DIV,
        ST_STEP_DWAIT,
        ST_STEP_APPLY,
        ST_GAIN_MUL,
        ST_GAIN_MWAIT,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/tsvr_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on tsvr_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module tsvr_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [tsvr_pkg::MUL_A_W-1:0] i_a,
    input  wire logic [tsvr_pkg::MUL_B_W-1:0] i_b,
    output logic                              o_done,
    output logic [tsvr_pkg::PROD_W-1:0]       o_product
);
    import tsvr_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_A_W-1:0] r_hi;
    logic [MUL_B_W-1:0] r_lo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [MUL_A_W:0]   w_sum;

    // Add the multiplicand when the current multiplier bit is set.
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    // Control: bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial product shifts right, product bits fill the low half.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= w_sum[MUL_A_W:1];
            r_lo <= {w_sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

`default_nettype wire

### hw/rtl/tsvr_div.sv
// Restoring divider producing one quotient bit per cycle.
// Depends on tsvr_pkg for dividend and divisor widths.
`timescale 1ns / 1ps
`default_nettype none

module tsvr_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [tsvr_pkg::DIV_N_W-1:0] i_dividend,
    input  wire logic [tsvr_pkg::DIV_D_W-1:0] i_divisor,
    output logic                              o_done,
    output logic [tsvr_pkg::DIV_N_W-1:0]      o_quotient
);
    import tsvr_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_D_W-1:0] r_d;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_N_W-1:0] r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_D_W:0]   w_trial;
    logic [DIV_D_W:0]   w_diff;
    logic               w_ge;

    // Bring down the next dividend bit and try a subtraction.
    assign w_trial = {r_rem, r_quo[DIV_N_W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_ge    = (w_trial >= {1'b0, r_d});

    // Control: bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: for a nonzero divisor the remainder always stays below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### hw/rtl/two_stage_volume_ramp_top.sv
// Two-stage volume ramp: base and adjust gain ramps, controller and output register.
// A set transaction multiplies the sample rate by the duration and divides by 1000;
// an advance transaction runs a multiply and a divide for each moving ramp, then the
// gain multiply, on the bit-serial multiplier and divider, which are shared.
// One transaction is worked on at a time; the next is taken while a result waits.
// Reset (synchronous, active low) gives unity gain on both ramps, no pending ramp,
// and a sample rate of 48000.
`timescale 1ns / 1ps
`default_nettype none

module two_stage_volume_ramp_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tsvr_pkg::RATE_W-1:0]   i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [tsvr_pkg::OP_W-1:0]     i_operation,
    input  wire logic [tsvr_pkg::LEVEL_W-1:0]  i_level,
    input  wire logic [tsvr_pkg::MS_W-1:0]     i_duration_ms,
    input  wire logic [tsvr_pkg::FRAMES_W-1:0] i_frames,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [tsvr_pkg::GAIN_W-1:0]        o_gain
);
    import tsvr_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [RATE_W-1:0]   r_sample_rate;
    logic [LEVEL_W-1:0]  r_level;
    logic [MS_W-1:0]     r_ms;
    logic [FRAMES_W-1:0] r_frames;
    logic                r_sel;
    logic [LEVEL_W-1:0]  r_value [2];
    logic [LEVEL_W-1:0]  r_goal  [2];
    logic [LEFT_W-1:0]   r_left  [2];
    logic                r_out_valid;
    logic [GAIN_W-1:0]   r_gain;

    logic                w_in_accept;
    logic                w_out_free;
    logic [LEVEL_W-1:0]  w_val;
    logic [LEVEL_W-1:0]  w_goal;
    logic [LEFT_W-1:0]   w_left;
    logic                w_up;
    logic [LEVEL_W-1:0]  w_diff;
    logic                w_step_skip;
    logic [LEFT_W-1:0]   w_count;
    logic [LEVEL_W-1:0]  w_mag;

    logic                w_mul_start;
    logic [MUL_A_W-1:0]  w_mul_a;
    logic [MUL_B_W-1:0]  w_mul_b;
    logic                w_mul_done;
    logic [PROD_W-1:0]   w_product;
    logic                w_div_start;
    logic [DIV_D_W-1:0]  w_divisor;
    logic                w_div_done;
    logic [DIV_N_W-1:0]  w_quotient;

    // Shared arithmetic units.
    tsvr_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    tsvr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_product),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Selected ramp and its step terms.
    assign w_val       = r_value[r_sel];
    assign w_goal      = r_goal[r_sel];
    assign w_left      = r_left[r_sel];
    assign w_up        = (w_goal >= w_val);
    assign w_diff      = w_up ? (w_goal - w_val) : (w_val - w_goal);
    assign w_step_skip = (w_left == '0) || (r_sample_rate == '0)
                         || ({{(LEFT_W-FRAMES_W){1'b0}}, r_frames} >= w_left);
    assign w_mag       = w_quotient[LEVEL_W-1:0];

    // Frame count of a set transaction, saturated to the counter width.
    assign w_count = (w_quotient[DIV_N_W-1:LEFT_W] != '0) ? FRAMES_MAX
                                                          : w_quotient[LEFT_W-1:0];

    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == OP_SET_BASE || i_operation == OP_SET_ADJUST) begin
                        n_state = ST_SET_MUL;
                    end else if (i_operation == OP_ADVANCE) begin
                        n_state = ST_STEP_CHECK;
                    end
                end
            end
            ST_SET_MUL:    n_state = ST_SET_MWAIT;
            ST_SET_MWAIT:  if (w_mul_done) n_state = ST_SET_DIV;
            ST_SET_DIV:    n_state = ST_SET_DWAIT;
            ST_SET_DWAIT:  if (w_div_done) n_state = ST_SET_APPLY;
            ST_SET_APPLY:  n_state = ST_IDLE;
            ST_STEP_CHECK: begin
                if (!w_step_skip) begin
                    n_state = ST_STEP_MWAIT;
                end else begin
                    n_state = r_sel ? ST_GAIN_MUL : ST_STEP_CHECK;
                end
            end
            ST_STEP_MWAIT: if (w_mul_done) n_state = ST_STEP_DIV;
            ST_STEP_DIV:   n_state = ST_STEP_DWAIT;
            ST_STEP_DWAIT: if (w_div_done) n_state = ST_STEP_APPLY;
            ST_STEP_APPLY: n_state = r_sel ? ST_GAIN_MUL : ST_STEP_CHECK;
            ST_GAIN_MUL:   n_state = ST_GAIN_MWAIT;
            ST_GAIN_MWAIT: if (w_mul_done) n_state = ST_OUT;
            ST_OUT:        if (w_out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // Controller outputs: unit starts and operand selection.
    always_comb begin
        o_in_ready  = 1'b0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_mul_a     = {{(MUL_A_W-LEVEL_W){1'b0}}, r_value[0]};
        w_mul_b     = r_value[1];
        w_divisor   = w_left;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_SET_MUL: begin
                w_mul_start = 1'b1;
                w_mul_a     = r_sample_rate;
                w_mul_b     = r_ms;
            end
            ST_SET_DIV: begin
                w_div_start = 1'b1;
                w_divisor   = DIV_D_W'(MS_PER_S);
            end
            ST_STEP_CHECK: begin
                w_mul_start = !w_step_skip;
                w_mul_a     = {{(MUL_A_W-LEVEL_W){1'b0}}, w_diff};
                w_mul_b     = r_frames;
            end
            ST_STEP_DIV: w_div_start = 1'b1;
            ST_GAIN_MUL: w_mul_start = 1'b1;
            default: begin
            end
        endcase
    end

    // State register and sample-rate register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_sample_rate <= RATE_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_sample_rate <= i_cfg_data;
            end
        end
    end

    // Captured transaction fields.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_level  <= i_level;
            r_ms     <= i_duration_ms;
            r_frames <= i_frames;
        end
    end

    // Ramp state: set commands, advance steps and ramp selection.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel      <= 1'b0;
            r_value[0] <= UNITY;
            r_value[1] <= UNITY;
            r_goal[0]  <= UNITY;
            r_goal[1]  <= UNITY;
            r_left[0]  <= '0;
            r_left[1]  <= '0;
        end else begin
            if (w_in_accept) begin
                r_sel <= (i_operation == OP_SET_ADJUST);
            end
            case (r_state)
                ST_SET_APPLY: begin
                    r_goal[r_sel] <= r_level;
                    if (w_count == '0 || w_val == r_level) begin
                        r_value[r_sel] <= r_level;
                        r_left[r_sel]  <= '0;
                    end else begin
                        r_left[r_sel] <= w_count;
                    end
                end
                ST_STEP_CHECK: begin
                    if (w_step_skip) begin
                        r_sel <= 1'b1;
                        // A finished ramp holds its goal, one the frames reach ends at it; a frozen one stays put.
                        if (w_left == '0) begin
                            r_value[r_sel] <= w_goal;
                        end else if (r_sample_rate != '0) begin
                            r_value[r_sel] <= w_goal;
                            r_left[r_sel]  <= '0;
                        end
                    end
                end
                ST_STEP_APPLY: begin
                    r_sel          <= 1'b1;
                    r_value[r_sel] <= w_up ? (w_val + w_mag) : (w_val - w_mag);
                    r_left[r_sel]  <= w_left - {{(LEFT_W-FRAMES_W){1'b0}}, r_frames};
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: the product in Q2.15.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_gain <= w_product[Q_FRAC +: GAIN_W];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gain      = r_gain;

    // A pending ramp never sits on its goal.
    a_base_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left[0] != '0) |-> (r_value[0] != r_goal[0]))
        else $error("base ramp pending at its goal");

    a_adjust_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left[1] != '0) |-> (r_value[1] != r_goal[1]))
        else $error("adjust ramp pending at its goal");

    // A valid command leaves the idle state.
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_operation == OP_SET_BASE || i_operation == OP_SET_ADJUST
                         || i_operation == OP_ADVANCE)) |=> (r_state != ST_IDLE))
        else $error("command accepted without work");

    // A result only appears from the output state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside output state");

endmodule

`default_nettype wire
